/* src/airflow_adc_to_velocity_macros.svh */
// assertion macros shared by the checker
`ifndef AIRFLOW_ADC_TO_VELOCITY_MACROS_SVH
`define AIRFLOW_ADC_TO_VELOCITY_MACROS_SVH

// implication in the same cycle, ignored while in reset
`define ACV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acv: same-cycle check failed");

// implication into the next cycle, ignored while in reset
`define ACV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acv: next-cycle check failed");

// what must hold in the cycle after reset is sampled
`define ACV_ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("acv: post-reset check failed");

`endif

/* src/acv_pkg.sv */
package acv_pkg;

  // field widths
  localparam int ADC_W      = 16;
  localparam int TEMP_W     = 8;
  localparam int VEL_W      = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int FACT_W     = 18;  // K + T - 25
  localparam int PROD_W     = 35;  // signed product ahead of the division
  localparam int DEN_W      = 17;  // signed divisor
  localparam int NUM2_W     = 38;  // 2n + d after sign normalising
  localparam int DIV_NUM_W  = NUM2_W;
  localparam int DIV_DEN_W  = DEN_W + 1;
  localparam int QUO_W      = DIV_NUM_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

  // temperature limits
  localparam int TEMP_REF    = 25;
  localparam int TEMP_BYPASS = 50;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEF = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ADC_PT0   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ADC_PT1   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ADC_PT2   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_VEL_PT0   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_VEL_PT1   = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_VEL_PT2   = CFG_IDX_W'(7);

  // calibration modes
  localparam logic [MODE_W-1:0] MODE_TWO_POINT   = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_THREE_POINT = MODE_W'(1);

  typedef struct packed {
    logic capture;
    logic comp_load;
    logic vel_load;
    logic prep;
    logic div_start;
    logic comp_bypass;
    logic comp_from_div;
    logic comp_commit;
    logic vel_clear;
    logic vel_from_div;
    logic vel_commit;
    logic out_load;
  } acv_cmd_t;

  typedef struct packed {
    logic recomp;
    logic bypass;
    logic comp_same;
    logic seg_zero;
    logic div_done;
    logic out_free;
  } acv_status_t;

endpackage

/* src/acv_sample_if.sv */
interface acv_sample_if;
  logic                             valid;
  logic                             ready;
  logic        [acv_pkg::ADC_W-1:0]  adc_sample;
  logic signed [acv_pkg::TEMP_W-1:0] temperature;

  modport source (output valid, adc_sample, temperature, input ready);
  modport sink (input valid, adc_sample, temperature, output ready);
endinterface

/* src/acv_result_if.sv */
interface acv_result_if;
  logic                       valid;
  logic                       ready;
  logic [acv_pkg::VEL_W-1:0]  velocity_milli;
  logic [acv_pkg::ADC_W-1:0]  compensated_adc;
  logic                       adc_changed;
  logic                       velocity_changed;

  modport source (output valid, velocity_milli, compensated_adc, adc_changed,
                  velocity_changed, input ready);
  modport sink (input valid, velocity_milli, compensated_adc, adc_changed,
                velocity_changed, output ready);
endinterface

/* src/acv_cfg_if.sv */
interface acv_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [acv_pkg::CFG_IDX_W-1:0]   index;
  logic [acv_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/airflow_adc_to_velocity.sv */
// airflow velocity from a temperature-compensated converter sample
//
// channels: sample takes adc_sample and temperature, result gives
// velocity_milli, compensated_adc, adc_changed and velocity_changed, cfg
// writes one of eight calibration registers (index, data) and is always ready
// one result goes out for every sample request, in order
// a request is worked on alone; sample.ready is low from acceptance until the
// result has been loaded into the output register
// paths: the result follows with no division when sample and temperature are
// unchanged, or when compensation is bypassed and the compensated value is
// unchanged; the compensation division alone runs when it gives the held value,
// and both divisions can run (compensation and interpolation), on the shared
// 1-bit-a-cycle restoring divider, 38 steps plus sign fix-up per division
// the result is held in an output register; a new sample is taken while the
// previous result still waits, but the next result only loads once the
// receiver has taken the old one, so a stall on result stops the block after
// one request
// reset (synchronous, active high) clears the configuration, held values,
// control state and output valid flag; cfg writes belong in idle periods only
module airflow_adc_to_velocity (
  input logic          clk,
  input logic          rst,
  acv_sample_if.sink   sample,
  acv_result_if.source result,
  acv_cfg_if.sink      cfg
);

  acv_pkg::acv_cmd_t    cmd;
  acv_pkg::acv_status_t status;

  // registers are plain flops, so writes never stall
  assign cfg.ready = 1'b1;

  // sequencer: walks compensation, compare, segment pick, interpolation
  acv_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // held state, calibration registers, multiplier, divider and output stage
  acv_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_adc   (sample.adc_sample),
    .sample_temp  (sample.temperature),
    .cfg_write    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .out_velocity (result.velocity_milli),
    .out_comp     (result.compensated_adc),
    .out_adc_chg  (result.adc_changed),
    .out_vel_chg  (result.velocity_changed)
  );

endmodule

/* src/acv_divider.sv */
module acv_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 num_neg,
  input  logic        [acv_pkg::DIV_NUM_W-1:0] num_mag,
  input  logic        [acv_pkg::DIV_DEN_W-1:0] den,
  output logic                                 done,
  output logic signed [acv_pkg::QUO_W-1:0]     quotient
);

  logic                              busy;
  logic                              fix;
  logic [acv_pkg::DIV_CNT_W-1:0]     cnt;
  logic [acv_pkg::DIV_NUM_W-1:0]     quo;
  logic [acv_pkg::DIV_DEN_W-1:0]     rem;
  logic [acv_pkg::DIV_DEN_W-1:0]     den_reg;
  logic                              neg;
  logic [acv_pkg::DIV_DEN_W:0]       trial;
  logic [acv_pkg::DIV_DEN_W:0]       diff;
  logic                              step_bit;
  logic [acv_pkg::DIV_DEN_W-1:0]     step_rem;
  logic [acv_pkg::QUO_W-1:0]         q_up;

  // one restoring step per cycle
  assign trial    = {rem, quo[acv_pkg::DIV_NUM_W-1]};
  assign diff     = trial - {1'b0, den_reg};
  assign step_bit = (trial >= {1'b0, den_reg});
  assign step_rem = step_bit ? diff[acv_pkg::DIV_DEN_W-1:0]
                             : trial[acv_pkg::DIV_DEN_W-1:0];

  // floor for a negative numerator: round the magnitude quotient up
  assign q_up = {1'b0, quo} + acv_pkg::QUO_W'(rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == acv_pkg::DIV_LAST) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num_mag;
      rem     <= '0;
      den_reg <= den;
      neg     <= num_neg;
    end else if (busy) begin
      quo <= {quo[acv_pkg::DIV_NUM_W-2:0], step_bit};
      rem <= step_rem;
    end else if (fix) begin
      quotient <= neg ? $signed(-q_up) : $signed({1'b0, quo});
    end
  end

endmodule

/* src/acv_datapath.sv */
module acv_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  acv_pkg::acv_cmd_t                 cmd,
  output acv_pkg::acv_status_t              status,
  input  logic        [acv_pkg::ADC_W-1:0]  sample_adc,
  input  logic signed [acv_pkg::TEMP_W-1:0] sample_temp,
  input  logic                              cfg_write,
  input  logic [acv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [acv_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [acv_pkg::VEL_W-1:0]         out_velocity,
  output logic [acv_pkg::ADC_W-1:0]         out_comp,
  output logic                              out_adc_chg,
  output logic                              out_vel_chg
);

  localparam int SAT_W = acv_pkg::QUO_W + 1;
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(65535);
  localparam logic signed [acv_pkg::TEMP_W-1:0] TEMP_LIMIT =
    acv_pkg::TEMP_W'(acv_pkg::TEMP_BYPASS);

  function automatic logic [15:0] sat16(input logic signed [SAT_W-1:0] v);
    logic [15:0] r;
    if (v[SAT_W-1]) r = '0;
    else if (v > SAT_MAX) r = '1;
    else r = v[15:0];
    return r;
  endfunction

  // configuration
  logic signed [15:0]                k_coef;
  logic [acv_pkg::MODE_W-1:0]        mode;
  logic [acv_pkg::ADC_W-1:0]         apt0, apt1, apt2;
  logic [acv_pkg::VEL_W-1:0]         vpt0, vpt1, vpt2;

  // held state
  logic [acv_pkg::ADC_W-1:0]         held_sample;
  logic [acv_pkg::TEMP_W-1:0]        held_temp;
  logic [acv_pkg::ADC_W-1:0]         held_comp;
  logic [acv_pkg::VEL_W-1:0]         held_vel;

  // per-request registers
  logic [acv_pkg::ADC_W-1:0]         adc_reg;
  logic signed [acv_pkg::TEMP_W-1:0] temp_reg;
  logic                              adc_chg;
  logic                              recomp;
  logic                              vel_chg;
  logic [acv_pkg::ADC_W-1:0]         comp_new;
  logic [acv_pkg::VEL_W-1:0]         vel_new;
  logic signed [acv_pkg::PROD_W-1:0] prod;
  logic signed [acv_pkg::DEN_W-1:0]  den;
  logic signed [acv_pkg::NUM2_W-1:0] n2;
  logic [acv_pkg::DIV_DEN_W-1:0]     d2;

  // combinational
  logic signed [acv_pkg::FACT_W-1:0] factor;
  logic signed [acv_pkg::PROD_W-1:0] comp_prod;
  logic                              seg2;
  logic [acv_pkg::ADC_W-1:0]         a_lo, a_hi;
  logic [acv_pkg::VEL_W-1:0]         v_lo, v_hi;
  logic signed [acv_pkg::DEN_W-1:0]  da, dc, dv;
  logic signed [acv_pkg::PROD_W-1:0] vel_prod;
  logic [acv_pkg::DEN_W-1:0]         dabs;
  logic signed [acv_pkg::NUM2_W-1:0] prod_x2;
  logic signed [acv_pkg::NUM2_W-1:0] dabs_ext;
  logic signed [acv_pkg::NUM2_W-1:0] n2_next;
  logic [acv_pkg::DIV_NUM_W-1:0]     num_mag;
  logic                              div_done;
  logic signed [acv_pkg::QUO_W-1:0]  quotient;
  logic signed [SAT_W-1:0]           vel_sum;
  logic                              mode_active;

  // compensation: adc * (K + T - 25) / K
  assign factor = acv_pkg::FACT_W'(k_coef) + acv_pkg::FACT_W'(temp_reg)
                - acv_pkg::FACT_W'(acv_pkg::TEMP_REF);
  assign comp_prod = acv_pkg::PROD_W'($signed({1'b0, adc_reg}))
                   * acv_pkg::PROD_W'(factor);

  // segment selection from the held compensated value
  assign mode_active = (mode == acv_pkg::MODE_TWO_POINT) ||
                       (mode == acv_pkg::MODE_THREE_POINT);
  assign seg2 = (mode == acv_pkg::MODE_THREE_POINT) && (held_comp > apt1);
  assign a_lo = seg2 ? apt1 : apt0;
  assign a_hi = seg2 ? apt2 : apt1;
  assign v_lo = seg2 ? vpt1 : vpt0;
  assign v_hi = seg2 ? vpt2 : vpt1;
  assign da   = $signed({1'b0, a_hi}) - $signed({1'b0, a_lo});
  assign dc   = $signed({1'b0, held_comp}) - $signed({1'b0, a_lo});
  assign dv   = $signed({1'b0, v_hi}) - $signed({1'b0, v_lo});
  assign vel_prod = acv_pkg::PROD_W'(dc) * acv_pkg::PROD_W'(dv);

  // round half up: floor((2n + d) / 2d) with d made positive
  assign dabs     = den[acv_pkg::DEN_W-1] ? acv_pkg::DEN_W'(-den) : acv_pkg::DEN_W'(den);
  assign prod_x2  = acv_pkg::NUM2_W'(prod) <<< 1;
  assign dabs_ext = $signed({{(acv_pkg::NUM2_W - acv_pkg::DEN_W){1'b0}}, dabs});
  assign n2_next  = den[acv_pkg::DEN_W-1] ? (dabs_ext - prod_x2) : (prod_x2 + dabs_ext);
  assign num_mag  = n2[acv_pkg::NUM2_W-1] ? acv_pkg::DIV_NUM_W'(-n2)
                                          : acv_pkg::DIV_NUM_W'(n2);

  assign vel_sum = SAT_W'($signed({1'b0, v_lo})) + SAT_W'(quotient);

  acv_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num_neg  (n2[acv_pkg::NUM2_W-1]),
    .num_mag  (num_mag),
    .den      (d2),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    status.recomp    = recomp;
    status.bypass    = (k_coef == '0) || (temp_reg > TEMP_LIMIT);
    status.comp_same = (comp_new == held_comp);
    status.seg_zero  = !mode_active || (held_comp <= apt0) || (da == '0);
    status.div_done  = div_done;
    status.out_free  = !out_valid || out_ready;
  end

  // configuration and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      k_coef      <= '0;
      mode        <= '0;
      apt0        <= '0;
      apt1        <= '0;
      apt2        <= '0;
      vpt0        <= '0;
      vpt1        <= '0;
      vpt2        <= '0;
      held_sample <= '0;
      held_temp   <= '0;
      held_comp   <= '0;
      held_vel    <= '0;
      adc_chg     <= 1'b0;
      recomp      <= 1'b0;
      vel_chg     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          acv_pkg::REG_TEMP_COEF: k_coef <= $signed(cfg_data);
          acv_pkg::REG_MODE:      mode   <= cfg_data[acv_pkg::MODE_W-1:0];
          acv_pkg::REG_ADC_PT0:   apt0   <= cfg_data;
          acv_pkg::REG_ADC_PT1:   apt1   <= cfg_data;
          acv_pkg::REG_ADC_PT2:   apt2   <= cfg_data;
          acv_pkg::REG_VEL_PT0:   vpt0   <= cfg_data;
          acv_pkg::REG_VEL_PT1:   vpt1   <= cfg_data;
          acv_pkg::REG_VEL_PT2:   vpt2   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        adc_chg     <= (sample_adc != held_sample);
        recomp      <= (sample_adc != held_sample) ||
                       (acv_pkg::TEMP_W'(sample_temp) != held_temp);
        vel_chg     <= 1'b0;
        held_sample <= sample_adc;
        held_temp   <= acv_pkg::TEMP_W'(sample_temp);
      end
      if (cmd.comp_commit) held_comp <= comp_new;
      if (cmd.vel_commit && (vel_new != held_vel)) begin
        held_vel <= vel_new;
        vel_chg  <= 1'b1;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      adc_reg  <= sample_adc;
      temp_reg <= sample_temp;
    end
    if (cmd.comp_load) begin
      prod <= comp_prod;
      den  <= acv_pkg::DEN_W'(k_coef);
    end else if (cmd.vel_load) begin
      prod <= vel_prod;
      den  <= da;
    end
    if (cmd.prep) begin
      n2 <= n2_next;
      d2 <= {dabs, 1'b0};
    end
    if (cmd.comp_bypass) comp_new <= adc_reg;
    else if (cmd.comp_from_div) comp_new <= sat16(SAT_W'(quotient));
    if (cmd.vel_clear) vel_new <= '0;
    else if (cmd.vel_from_div) vel_new <= sat16(vel_sum);
    if (cmd.out_load) begin
      out_velocity <= held_vel;
      out_comp     <= held_comp;
      out_adc_chg  <= adc_chg;
      out_vel_chg  <= vel_chg;
    end
  end

endmodule

/* src/acv_ctrl.sv */
module acv_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  acv_pkg::acv_status_t  status,
  output acv_pkg::acv_cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COMP_PREP,
    ST_COMP_START,
    ST_COMP_WAIT,
    ST_COMPARE,
    ST_SEG,
    ST_VEL_PREP,
    ST_VEL_START,
    ST_VEL_WAIT,
    ST_VEL_UPD,
    ST_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (sample_valid && sample_ready) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.recomp) begin
          state_next = ST_DONE;
        end else if (status.bypass) begin
          cmd.comp_bypass = 1'b1;
          state_next      = ST_COMPARE;
        end else begin
          cmd.comp_load = 1'b1;
          state_next    = ST_COMP_PREP;
        end
      end
      ST_COMP_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_COMP_START;
      end
      ST_COMP_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_COMP_WAIT;
      end
      ST_COMP_WAIT: begin
        if (status.div_done) begin
          cmd.comp_from_div = 1'b1;
          state_next        = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (status.comp_same) begin
          state_next = ST_DONE;
        end else begin
          cmd.comp_commit = 1'b1;
          state_next      = ST_SEG;
        end
      end
      ST_SEG: begin
        if (status.seg_zero) begin
          cmd.vel_clear = 1'b1;
          state_next    = ST_VEL_UPD;
        end else begin
          cmd.vel_load = 1'b1;
          state_next   = ST_VEL_PREP;
        end
      end
      ST_VEL_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_VEL_START;
      end
      ST_VEL_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_VEL_WAIT;
      end
      ST_VEL_WAIT: begin
        if (status.div_done) begin
          cmd.vel_from_div = 1'b1;
          state_next       = ST_VEL_UPD;
        end
      end
      ST_VEL_UPD: begin
        cmd.vel_commit = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_ready <= 1'b1;
    end else begin
      state        <= state_next;
      sample_ready <= (state_next == ST_IDLE);
    end
  end

endmodule

/* src/acv_checker.sv */
`include "airflow_adc_to_velocity_macros.svh"

module acv_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_valid,
  input logic                      s_ready,
  input logic                      r_valid,
  input logic                      r_ready,
  input logic [acv_pkg::VEL_W-1:0] r_velocity,
  input logic [acv_pkg::ADC_W-1:0] r_comp
);

  // idle and empty straight after reset
  `ACV_ASSERT_AFTER_RESET(a_reset_idle, clk, rst, s_ready && !r_valid)

  // one request at a time: busy right after acceptance
  `ACV_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_valid && s_ready, !s_ready)

  // a new result only follows a busy cycle
  `ACV_ASSERT_NOW(a_result_after_work, clk, rst, $rose(r_valid), $past(!s_ready))

  // stalled result holds
  `ACV_ASSERT_NEXT(a_result_hold, clk, rst, r_valid && !r_ready,
                   r_valid && $stable(r_velocity) && $stable(r_comp))

endmodule

bind airflow_adc_to_velocity acv_checker u_acv_checker (
  .clk        (clk),
  .rst        (rst),
  .s_valid    (sample.valid),
  .s_ready    (sample.ready),
  .r_valid    (result.valid),
  .r_ready    (result.ready),
  .r_velocity (result.velocity_milli),
  .r_comp     (result.compensated_adc)
);
